// ----- sv/spr_pkg.sv -----
// ----------------------------------------------------------------------------
// spr_pkg
// Shared widths, register indexes and controller states for the servo
// position ramp generator.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int PCT_W      = 7;   // opening percent
  localparam int STEP_W     = 8;   // ramp step count
  localparam int WAIT_W     = 16;  // per-step wait / delay
  localparam int PULSE_W    = 12;  // servo pulse value
  localparam int DIFF_W     = PULSE_W + 1;  // signed open - closed
  localparam int CHANGE_W   = PCT_W + 1;    // signed target - position
  localparam int PROD_W     = PCT_W + PULSE_W;  // |change| * |diff|
  localparam int DEN_W      = 15;  // 100 * steps fits here
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam logic [PCT_W-1:0]   PCT_MAX      = 7'd100;
  localparam logic [PULSE_W-1:0] PULSE_MAX    = 12'hFFF;
  localparam logic [DEN_W-1:0]   PERCENT_DEN  = 15'd100;

  localparam logic [PULSE_W-1:0] CLOSED_RST = 12'd0;
  localparam logic [PULSE_W-1:0] OPEN_RST   = 12'd4095;
  localparam logic [WAIT_W-1:0]  LONG_RST   = 16'd1000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PULSE_CLOSED  = 2'd0,
    CFG_PULSE_OPEN    = 2'd1,
    CFG_LONG_DELAY    = 2'd2,
    CFG_SIMULATE_ONLY = 2'd3
  } cfg_reg_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,  // |change| * |diff|
    S_DIV1 = 8'b0000_0100,  // pulse increment
    S_MUL2 = 8'b0000_1000,  // position * |diff|
    S_DIV2 = 8'b0001_0000,  // starting accumulator
    S_DIV3 = 8'b0010_0000,  // percent increment
    S_ADV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

endpackage

// ----- sv/spr_serial_mul.sv -----
// ----------------------------------------------------------------------------
// spr_serial_mul
// Shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module spr_serial_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [spr_pkg::PCT_W-1:0]        mplier,
  input  logic [spr_pkg::PULSE_W-1:0]      mcand,
  output logic                             done,
  output logic [spr_pkg::PROD_W-1:0]       product
);

  localparam int CNT_W = $clog2(spr_pkg::PCT_W + 1);

  logic                          busy_r;
  logic                          done_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [spr_pkg::PCT_W-1:0]     a_r;
  logic [spr_pkg::PULSE_W-1:0]   b_r;
  logic [spr_pkg::PROD_W-1:0]    p_r;
  logic [spr_pkg::PROD_W-1:0]    p_nxt;

  always_comb begin
    p_nxt = {p_r[spr_pkg::PROD_W-2:0], 1'b0}
          + (a_r[spr_pkg::PCT_W-1] ? spr_pkg::PROD_W'(b_r) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(spr_pkg::PCT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= mplier;
      b_r <= mcand;
      p_r <= '0;
    end else if (busy_r) begin
      a_r <= {a_r[spr_pkg::PCT_W-2:0], 1'b0};
      p_r <= p_nxt;
    end
  end

  assign done    = done_r;
  assign product = p_r;

endmodule

// ----- sv/spr_serial_div.sv -----
// ----------------------------------------------------------------------------
// spr_serial_div
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// loaded left-aligned; after N iterations the low N bits hold the quotient.
// ----------------------------------------------------------------------------
module spr_serial_div #(
  parameter int NUM_W  = 27,
  parameter int ITER_W = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [spr_pkg::DEN_W-1:0]     den,
  input  logic [ITER_W-1:0]             iters,
  output logic                          done,
  output logic [NUM_W-1:0]              quot
);

  localparam int DW = spr_pkg::DEN_W;

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [NUM_W-1:0]  q_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     den_r;
  logic [DW:0]       rem_sh;
  logic [DW+1:0]     trial;
  logic              fits;
  logic [DW-1:0]     rem_nxt;
  logic [NUM_W-1:0]  q_nxt;

  always_comb begin
    rem_sh  = {rem_r, q_r[NUM_W-1]};
    trial   = {1'b0, rem_sh} - {2'b00, den_r};
    fits    = ~trial[DW+1];
    rem_nxt = fits ? trial[DW-1:0] : rem_sh[DW-1:0];
    q_nxt   = {q_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- sv/servo_position_ramp.sv -----
// ----------------------------------------------------------------------------
// servo_position_ramp
// Linear servo ramp: per request, advance one step toward the target
// opening and report the saturated pulse value and the delay to hold.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload (low bit up)
//  --------+------------------------------+---------------------------------
//  in      | in_tvalid/in_tready/in_tdata | target_percent, step_count,
//          |                              | step_wait
//  out     | out_tvalid/out_tready/...    | tdata: pulse_value, delay_out,
//          |                              | position_percent; tuser: strobe
//  cfg     | cfg_we/cfg_addr/cfg_wdata    | register index 0..3
//
// A request that keeps target and step count goes straight to the step
// update. A new target or step count, while the position differs from the
// target, runs the serial multiplier twice and the serial divider three
// times. Reset is synchronous, active low; in_tready is high from reset
// on, so a request can be taken as soon as reset is released. The next
// request is taken while a result waits in the output register; a stalled
// output holds the controller before the following result is loaded.
// ----------------------------------------------------------------------------
module servo_position_ramp #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // target_percent[6:0], step_count[14:7], step_wait[30:15]
  input  logic [spr_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pulse_value[11:0], delay_out[27:12], position_percent[34:28]
  output logic [spr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // write_strobe[0]
  output logic                              out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [spr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [spr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int PCT_W   = spr_pkg::PCT_W;
  localparam int PULSE_W = spr_pkg::PULSE_W;
  localparam int WAIT_W  = spr_pkg::WAIT_W;
  localparam int STEP_W  = spr_pkg::STEP_W;
  localparam int DEN_W   = spr_pkg::DEN_W;
  localparam int NUM_W   = spr_pkg::PROD_W + FRACTION_BITS;
  localparam int INC_W   = NUM_W + 1;
  localparam int ACC_W   = NUM_W + 2;
  localparam int PV_W    = ACC_W - FRACTION_BITS + 1;
  localparam int ITER_W  = $clog2(NUM_W + 1);

  spr_pkg::state_t state_r;

  // a unit is idle in its own state until it reports done; starting is keyed
  // to the first cycle in the state
  logic started_r;

  // configuration
  logic [PULSE_W-1:0] cfg_closed_r;
  logic [PULSE_W-1:0] cfg_open_r;
  logic [WAIT_W-1:0]  cfg_long_r;
  logic               cfg_sim_r;

  // ramp state
  logic [PCT_W-1:0]         pos_r;
  logic [PCT_W-1:0]         dest_r;
  logic [STEP_W-1:0]        ramp_steps_r;
  logic [STEP_W-1:0]        step_idx_r;
  logic signed [INC_W-1:0]  inc_r;
  logic [PCT_W-1:0]         pct_mag_r;
  logic                     pct_neg_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [PULSE_W-1:0]       pulse_r;
  logic [WAIT_W-1:0]        delay_r;

  // current request
  logic [PCT_W-1:0]   req_tgt_r;
  logic [WAIT_W-1:0]  req_wait_r;
  logic               moving_r;
  logic               adv_r;
  logic               change_neg_r;
  logic [PCT_W-1:0]   abs_change_r;
  logic               diff_neg_r;
  logic [PULSE_W-1:0] abs_diff_r;

  // output register
  logic                 out_tvalid_r;
  logic                 out_strobe_r;
  logic [PULSE_W-1:0]   out_pulse_r;
  logic [WAIT_W-1:0]    out_delay_r;
  logic [PCT_W-1:0]     out_pos_r;

  // input decode
  logic [PCT_W-1:0]            in_tgt;
  logic [STEP_W-1:0]           in_steps_raw;
  logic [STEP_W-1:0]           in_steps;
  logic [WAIT_W-1:0]           in_wait;
  logic [spr_pkg::CHANGE_W-1:0] change;
  logic [spr_pkg::DIFF_W-1:0]   diff;
  logic                        restart;
  logic                        in_fire;

  // arithmetic units
  logic                        mul_start;
  logic                        mul_done;
  logic [PCT_W-1:0]            mul_a;
  logic [spr_pkg::PROD_W-1:0]  mul_prod;
  logic                        div_start;
  logic                        div_done;
  logic [NUM_W-1:0]            div_num;
  logic [DEN_W-1:0]            div_den;
  logic [ITER_W-1:0]           div_iters;
  logic [NUM_W-1:0]            div_quot;
  logic [DEN_W-1:0]            den_steps;

  // step datapath
  logic [INC_W-1:0]    inc_mag;
  logic [ACC_W-1:0]    acc_mag;
  logic [PCT_W+1:0]    pos_sum;
  logic [PCT_W-1:0]    pos_step;
  logic                pv_round;
  logic [PV_W-1:0]     pv_sum;
  logic [PULSE_W-1:0]  pv_sat;
  logic                out_free;

  assign in_tgt       = in_tdata[6:0];
  assign in_steps_raw = in_tdata[14:7];
  assign in_wait      = in_tdata[30:15];
  assign in_steps     = (in_steps_raw == '0) ? STEP_W'(1) : in_steps_raw;
  assign change       = {1'b0, in_tgt} - {1'b0, pos_r};
  assign diff         = {1'b0, cfg_open_r} - {1'b0, cfg_closed_r};
  assign restart      = (pos_r != in_tgt) &&
                        ((ramp_steps_r != in_steps) || (dest_r != in_tgt));
  assign in_tready    = (state_r == spr_pkg::S_IDLE);
  assign in_fire      = in_tvalid && in_tready;
  assign out_free     = !out_tvalid_r || out_tready;

  // 100 * steps as shifts and adds
  assign den_steps = DEN_W'({ramp_steps_r, 6'b0}) + DEN_W'({ramp_steps_r, 5'b0})
                   + DEN_W'({ramp_steps_r, 2'b0});

  assign mul_a     = (state_r == spr_pkg::S_MUL1) ? abs_change_r : pos_r;
  assign mul_start = ((state_r == spr_pkg::S_MUL1) || (state_r == spr_pkg::S_MUL2))
                     && !started_r && !mul_done;

  always_comb begin
    div_num   = {mul_prod, {FRACTION_BITS{1'b0}}};
    div_den   = den_steps;
    div_iters = ITER_W'(NUM_W);
    unique case (state_r)
      spr_pkg::S_DIV2: begin
        div_den = spr_pkg::PERCENT_DEN;
      end
      spr_pkg::S_DIV3: begin
        div_num   = {abs_change_r, {(NUM_W-PCT_W){1'b0}}};
        div_den   = DEN_W'(ramp_steps_r);
        div_iters = ITER_W'(PCT_W);
      end
      default: begin
      end
    endcase
  end

  assign div_start = ((state_r == spr_pkg::S_DIV1) || (state_r == spr_pkg::S_DIV2) ||
                      (state_r == spr_pkg::S_DIV3)) && !started_r && !div_done;

  spr_serial_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mplier  (mul_a),
    .mcand   (abs_diff_r),
    .done    (mul_done),
    .product (mul_prod)
  );

  spr_serial_div #(
    .NUM_W  (NUM_W),
    .ITER_W (ITER_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .done  (div_done),
    .quot  (div_quot)
  );

  // signed results from magnitudes, truncation toward zero
  assign inc_mag = {1'b0, div_quot};
  assign acc_mag = {2'b00, div_quot};

  // position step, clamped to 0..127
  always_comb begin
    pos_sum = {2'b00, pos_r} + (pct_neg_r ? -{2'b00, pct_mag_r} : {2'b00, pct_mag_r});
    if (pos_sum[PCT_W+1]) begin
      pos_step = '0;
    end else if (pos_sum[PCT_W]) begin
      pos_step = '1;
    end else begin
      pos_step = pos_sum[PCT_W-1:0];
    end
  end

  // closed + trunc0(acc / 2^F): floor plus one when negative with a fraction
  always_comb begin
    pv_round = acc_r[ACC_W-1] & (|acc_r[FRACTION_BITS-1:0]);
    pv_sum   = PV_W'(signed'(acc_r[ACC_W-1:FRACTION_BITS])) + PV_W'(cfg_closed_r)
             + PV_W'(pv_round);
    if (pv_sum[PV_W-1]) begin
      pv_sat = '0;
    end else if (|pv_sum[PV_W-2:PULSE_W]) begin
      pv_sat = spr_pkg::PULSE_MAX;
    end else begin
      pv_sat = pv_sum[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_closed_r <= spr_pkg::CLOSED_RST;
      cfg_open_r   <= spr_pkg::OPEN_RST;
      cfg_long_r   <= spr_pkg::LONG_RST;
      cfg_sim_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (spr_pkg::cfg_reg_t'(cfg_addr))
        spr_pkg::CFG_PULSE_CLOSED:  cfg_closed_r <= cfg_wdata[PULSE_W-1:0];
        spr_pkg::CFG_PULSE_OPEN:    cfg_open_r   <= cfg_wdata[PULSE_W-1:0];
        spr_pkg::CFG_LONG_DELAY:    cfg_long_r   <= cfg_wdata[WAIT_W-1:0];
        spr_pkg::CFG_SIMULATE_ONLY: cfg_sim_r    <= cfg_wdata[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= spr_pkg::S_IDLE;
      started_r    <= 1'b0;
      pos_r        <= '0;
      dest_r       <= '0;
      ramp_steps_r <= '0;
      step_idx_r   <= '0;
      inc_r        <= '0;
      pct_mag_r    <= '0;
      pct_neg_r    <= 1'b0;
      acc_r        <= '0;
      pulse_r      <= '0;
      delay_r      <= '0;
      moving_r     <= 1'b0;
      adv_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if ((state_r == spr_pkg::S_OUT) && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (mul_done || div_done) begin
        started_r <= 1'b0;
      end else if (mul_start || div_start) begin
        started_r <= 1'b1;
      end
      unique case (state_r)
        spr_pkg::S_IDLE: begin
          if (in_fire) begin
            moving_r <= (pos_r != in_tgt);
            if (restart) begin
              ramp_steps_r <= in_steps;
              dest_r       <= in_tgt;
              step_idx_r   <= '0;
              pulse_r      <= cfg_closed_r;
              state_r      <= spr_pkg::S_MUL1;
            end else begin
              state_r <= spr_pkg::S_ADV;
            end
          end
        end
        spr_pkg::S_MUL1: begin
          if (mul_done) begin
            state_r <= spr_pkg::S_DIV1;
          end
        end
        spr_pkg::S_DIV1: begin
          if (div_done) begin
            inc_r   <= (change_neg_r ^ diff_neg_r) ? -signed'(inc_mag) : signed'(inc_mag);
            state_r <= spr_pkg::S_MUL2;
          end
        end
        spr_pkg::S_MUL2: begin
          if (mul_done) begin
            state_r <= spr_pkg::S_DIV2;
          end
        end
        spr_pkg::S_DIV2: begin
          if (div_done) begin
            acc_r   <= diff_neg_r ? -signed'(acc_mag) : signed'(acc_mag);
            state_r <= spr_pkg::S_DIV3;
          end
        end
        spr_pkg::S_DIV3: begin
          if (div_done) begin
            pct_mag_r <= div_quot[PCT_W-1:0];
            pct_neg_r <= change_neg_r;
            state_r   <= spr_pkg::S_ADV;
          end
        end
        spr_pkg::S_ADV: begin
          adv_r <= 1'b0;
          if (moving_r) begin
            if (step_idx_r < ramp_steps_r) begin
              step_idx_r <= step_idx_r + 1'b1;
              acc_r      <= acc_r + ACC_W'(inc_r);
              pos_r      <= pos_step;
              delay_r    <= req_wait_r;
              adv_r      <= 1'b1;
            end else begin
              // steps used up: snap to the target
              pos_r   <= req_tgt_r;
              delay_r <= cfg_long_r;
            end
          end else if (delay_r == req_wait_r) begin
            delay_r <= cfg_long_r;
          end
          state_r <= spr_pkg::S_OUT;
        end
        spr_pkg::S_OUT: begin
          if (out_free) begin
            if (adv_r) begin
              pulse_r <= pv_sat;
            end
            state_r <= spr_pkg::S_IDLE;
          end
        end
        default: begin
          state_r <= spr_pkg::S_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_tgt_r    <= in_tgt;
      req_wait_r   <= in_wait;
      change_neg_r <= change[spr_pkg::CHANGE_W-1];
      abs_change_r <= change[spr_pkg::CHANGE_W-1] ? PCT_W'(-change) : change[PCT_W-1:0];
      diff_neg_r   <= diff[spr_pkg::DIFF_W-1];
      abs_diff_r   <= diff[spr_pkg::DIFF_W-1] ? PULSE_W'(-diff) : diff[PULSE_W-1:0];
    end
    if ((state_r == spr_pkg::S_OUT) && out_free) begin
      out_strobe_r <= adv_r && !cfg_sim_r;
      out_pulse_r  <= adv_r ? pv_sat : pulse_r;
      out_delay_r  <= delay_r;
      out_pos_r    <= (pos_r > spr_pkg::PCT_MAX) ? spr_pkg::PCT_MAX : pos_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_strobe_r;
  assign out_tdata  = {5'b0, out_pos_r, out_delay_r, out_pulse_r};

endmodule
